[design/utx_pkg.sv]
// Shared types and constants for the text transcoder.
// Used by utx_front, utx_queue, utx_back and unicode_text_transcoder_top.
package utx_pkg;

  typedef enum logic [1:0] {
    SRC_BYTE   = 2'd0,
    SRC_UNIT16 = 2'd1,
    SRC_UTF8   = 2'd2,
    SRC_UTF16  = 2'd3
  } src_enc_t;

  typedef enum logic [1:0] {
    TGT_BYTE   = 2'd0,
    TGT_UNIT16 = 2'd1,
    TGT_UTF16  = 2'd2,
    TGT_NONE   = 2'd3
  } tgt_enc_t;

  // code 3 behaves as big endian
  typedef enum logic [1:0] {
    ORD_AUTO    = 2'd0,
    ORD_LITTLE  = 2'd1,
    ORD_BIG     = 2'd2,
    ORD_BIG_ALT = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    REG_SRC_ENC = 2'd0,
    REG_SRC_ORD = 2'd1,
    REG_TGT_ENC = 2'd2,
    REG_TGT_ORD = 2'd3
  } reg_index_t;

  localparam int unsigned CP_W        = 26;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  UTF8_LEAD_BASE = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD_SPAN = 8'h35;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4     = 8'hF0;
  localparam logic [5:0]  SURR_LEAD_TAG  = 6'b110110;
  localparam logic [5:0]  SURR_TRAIL_TAG = 6'b110111;
  localparam logic [15:0] BOM            = 16'hFEFF;
  localparam logic [15:0] BOM_SWAPPED    = 16'hFFFE;
  // (0xD800 << 10) + 0xDC00 - 0x10000
  localparam logic [27:0] SURR_OFFSET    = 28'h35FDC00;
  // 0xD800 - (0x10000 >> 10)
  localparam logic [15:0] LEAD_BIAS      = 16'hD7C0;

  typedef struct packed {
    src_enc_t src_enc;
    order_t   src_ord;
    tgt_enc_t tgt_enc;
    order_t   tgt_ord;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       starts_text;
    logic       ends_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // decoded request between front and back
  typedef struct packed {
    logic            mark;
    logic            has_cp;
    logic            ge;      // code point at or above 0x10000
    logic [CP_W-1:0] cp;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

[design/utx_front.sv]
// Front end: decodes source bytes, keeps partial-sequence state.
// Depends on utx_pkg.
module utx_front (
  input  logic            clk,
  input  logic            rst_n,
  input  utx_pkg::cfg_t   cfg,
  input  utx_pkg::in_t    in_item,
  input  logic            accept,
  output utx_pkg::entry_t entry
);

  logic [23:0] pend_bytes_r, pend_bytes_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [1:0]  need_cnt_r, need_cnt_nxt;
  logic        mark_r, mark_nxt;
  logic        checked_r, checked_nxt;
  logic        det_big_r, det_big_nxt;

  logic [23:0] pb, pb_n;
  logic [1:0]  pc, pc_n, nc, nc_n;
  logic        chk, chk_n, dbig, dbig_n, mk;
  logic [7:0]  b, first, third, lead_off;
  logic [15:0] u, le, lead, trail;
  logic [23:0] shifted;
  logic [26:0] sum;
  logic [27:0] diff;
  logic        src_big, mark_emit;

  always_comb begin
    b     = in_item.in_byte;
    pb    = in_item.starts_text ? 24'd0 : pend_bytes_r;
    pc    = in_item.starts_text ? 2'd0 : pend_cnt_r;
    nc    = in_item.starts_text ? 2'd0 : need_cnt_r;
    chk   = in_item.starts_text ? 1'b0 : checked_r;
    dbig  = in_item.starts_text ? 1'b0 : det_big_r;
    mk    = in_item.starts_text ? 1'b1 : mark_r;
    mark_emit = (cfg.tgt_enc == utx_pkg::TGT_UTF16) && (cfg.tgt_ord == utx_pkg::ORD_AUTO) && mk;
    src_big = (cfg.src_ord == utx_pkg::ORD_AUTO) ? dbig :
              (cfg.src_ord == utx_pkg::ORD_BIG || cfg.src_ord == utx_pkg::ORD_BIG_ALT);
    first    = pb[7:0];
    third    = pb[23:16];
    lead     = pb[15:0];
    lead_off = b - utx_pkg::UTF8_LEAD_BASE;
    shifted  = {pb[17:0], b[5:0]};
    le       = {b, first};
    u        = src_big ? {first, b} : {b, first};
    trail    = src_big ? {third, b} : {b, third};
    sum      = {1'b0, lead, 10'd0} + {11'd0, trail};
    diff     = {1'b0, sum} - utx_pkg::SURR_OFFSET;

    pb_n   = pb;
    pc_n   = pc;
    nc_n   = nc;
    chk_n  = chk;
    dbig_n = dbig;
    entry.mark   = mark_emit;
    entry.has_cp = 1'b0;
    entry.ge     = 1'b0;
    entry.cp     = '0;

    unique case (cfg.src_enc)
      utx_pkg::SRC_BYTE: begin
        entry.has_cp = 1'b1;
        entry.cp     = utx_pkg::CP_W'(b);
      end
      utx_pkg::SRC_UNIT16: begin
        if (pc == 2'd0) begin
          pb_n = {16'd0, b};
          pc_n = 2'd1;
        end else begin
          pb_n = '0;
          pc_n = 2'd0;
          entry.has_cp = 1'b1;
          entry.cp = (cfg.src_ord == utx_pkg::ORD_BIG || cfg.src_ord == utx_pkg::ORD_BIG_ALT) ?
                     utx_pkg::CP_W'({first, b}) : utx_pkg::CP_W'({b, first});
        end
      end
      utx_pkg::SRC_UTF8: begin
        if (nc != 2'd0) begin
          nc_n = nc - 2'd1;
          if (nc == 2'd1) begin
            pb_n = '0;
            entry.has_cp = 1'b1;
            entry.cp     = utx_pkg::CP_W'(shifted);
            entry.ge     = |shifted[23:16];
          end else begin
            pb_n = shifted;
          end
        end else if (lead_off < utx_pkg::UTF8_LEAD_SPAN) begin
          if (b < utx_pkg::UTF8_LEAD3) begin
            pb_n = {19'd0, b[4:0]};
            nc_n = 2'd1;
          end else if (b < utx_pkg::UTF8_LEAD4) begin
            pb_n = {20'd0, b[3:0]};
            nc_n = 2'd2;
          end else begin
            pb_n = {21'd0, b[2:0]};
            nc_n = 2'd3;
          end
        end else begin
          entry.has_cp = 1'b1;
          entry.cp     = utx_pkg::CP_W'(b);
        end
      end
      utx_pkg::SRC_UTF16: begin
        case (pc)
          2'd0: begin
            pb_n = {16'd0, b};
            pc_n = 2'd1;
          end
          2'd2: begin
            pb_n = {b, pb[15:0]};
            pc_n = 2'd3;
          end
          2'd1: begin
            if (cfg.src_ord == utx_pkg::ORD_AUTO && !chk) begin
              chk_n = 1'b1;
            end
            if (cfg.src_ord == utx_pkg::ORD_AUTO && !chk &&
                (le == utx_pkg::BOM_SWAPPED || le == utx_pkg::BOM)) begin
              // order mark is consumed
              dbig_n = dbig | (le == utx_pkg::BOM_SWAPPED);
              pb_n   = '0;
              pc_n   = 2'd0;
            end else if (u[15:10] == utx_pkg::SURR_LEAD_TAG) begin
              pb_n = {8'd0, u};
              pc_n = 2'd2;
            end else begin
              pb_n = '0;
              pc_n = 2'd0;
              entry.has_cp = 1'b1;
              entry.cp     = utx_pkg::CP_W'(u);
            end
          end
          default: begin
            // surrogate pair; wrapped results count as above 0x10000
            pb_n = '0;
            pc_n = 2'd0;
            entry.has_cp = 1'b1;
            entry.cp     = diff[utx_pkg::CP_W-1:0];
            entry.ge     = diff[27] | (|diff[26:16]);
          end
        endcase
      end
      default: begin
        entry.has_cp = 1'b0;
      end
    endcase

    if (in_item.ends_text) begin
      pb_n = '0;
      pc_n = 2'd0;
      nc_n = 2'd0;
    end
  end

  always_comb begin
    pend_bytes_nxt = pend_bytes_r;
    pend_cnt_nxt   = pend_cnt_r;
    need_cnt_nxt   = need_cnt_r;
    mark_nxt       = mark_r;
    checked_nxt    = checked_r;
    det_big_nxt    = det_big_r;
    if (accept) begin
      pend_bytes_nxt = pb_n;
      pend_cnt_nxt   = pc_n;
      need_cnt_nxt   = nc_n;
      mark_nxt       = mk & ~mark_emit;
      checked_nxt    = chk_n;
      det_big_nxt    = dbig_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bytes_r <= '0;
      pend_cnt_r   <= '0;
      need_cnt_r   <= '0;
      mark_r       <= 1'b1;
      checked_r    <= 1'b0;
      det_big_r    <= 1'b0;
    end else begin
      pend_bytes_r <= pend_bytes_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      need_cnt_r   <= need_cnt_nxt;
      mark_r       <= mark_nxt;
      checked_r    <= checked_nxt;
      det_big_r    <= det_big_nxt;
    end
  end

endmodule

[design/utx_queue.sv]
// Short request queue between front and back end.
// Depends on utx_pkg.
module utx_queue #(
  parameter int unsigned DEPTH = utx_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utx_pkg::entry_t   wr_data,
  input  logic              pop,
  output utx_pkg::entry_t   rd_data,
  output utx_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utx_pkg::entry_t  slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & stat.valid;
  assign rd_data    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/utx_back.sv]
// Back end: encodes one queued request into target bytes, one per cycle while the output is popped or empty.
// Depends on utx_pkg.
module utx_back (
  input  logic             clk,
  input  logic             rst_n,
  input  utx_pkg::cfg_t    cfg,
  input  utx_pkg::entry_t  req,
  input  logic             req_valid,
  output logic             req_done,
  input  logic             pop,
  output logic             empty,
  output utx_pkg::out_t    out_item
);

  logic [2:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  utx_pkg::out_t       out_r, out_nxt;

  logic                tgt_big, can_load, load, last;
  logic [2:0]          cp_n, n, j_full;
  logic [15:0]         unit0, unit1, lead;
  logic [7:0]          cpb [4];
  logic [7:0]          mark_b [2];
  logic [7:0]          sel_byte;

  always_comb begin
    tgt_big = (cfg.tgt_ord == utx_pkg::ORD_BIG || cfg.tgt_ord == utx_pkg::ORD_BIG_ALT);
    lead    = req.cp[25:10] + utx_pkg::LEAD_BIAS;
    unit0   = req.cp[15:0];
    unit1   = {utx_pkg::SURR_TRAIL_TAG, req.cp[9:0]};
    cp_n    = 3'd0;
    unique case (cfg.tgt_enc)
      utx_pkg::TGT_BYTE:   cp_n = 3'd1;
      utx_pkg::TGT_UNIT16: cp_n = 3'd2;
      utx_pkg::TGT_UTF16: begin
        cp_n = req.ge ? 3'd4 : 3'd2;
        if (req.ge) begin
          unit0 = lead;
        end
      end
      default:             cp_n = 3'd0;
    endcase
    if (!req.has_cp) begin
      cp_n = 3'd0;
    end
    cpb[0] = tgt_big ? unit0[15:8] : unit0[7:0];
    cpb[1] = tgt_big ? unit0[7:0]  : unit0[15:8];
    cpb[2] = tgt_big ? unit1[15:8] : unit1[7:0];
    cpb[3] = tgt_big ? unit1[7:0]  : unit1[15:8];
    if (cfg.tgt_enc == utx_pkg::TGT_BYTE) begin
      cpb[0] = req.cp[7:0];
    end
    mark_b[0] = tgt_big ? utx_pkg::BOM[15:8] : utx_pkg::BOM[7:0];
    mark_b[1] = tgt_big ? utx_pkg::BOM[7:0]  : utx_pkg::BOM[15:8];

    n      = {1'b0, req.mark, 1'b0} + cp_n;
    j_full = req.mark ? idx_r - 3'd2 : idx_r;
    if (req.mark && idx_r < 3'd2) begin
      sel_byte = mark_b[idx_r[0]];
    end else begin
      sel_byte = cpb[j_full[1:0]];
    end

    can_load = ~out_valid_r | pop;
    last     = (idx_r == n - 3'd1);
    load     = req_valid & (n != 3'd0) & can_load;
    req_done = req_valid & ((n == 3'd0) | (can_load & last));
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~pop;
    if (load) begin
      idx_nxt           = last ? 3'd0 : idx_r + 3'd1;
      out_nxt.out_byte    = sel_byte;
      out_nxt.last_of_run = last;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign empty    = ~out_valid_r;
  assign out_item = out_r;

endmodule

[design/unicode_text_transcoder_top.sv]
// Text transcoder top level: config registers, front, request queue, back.
// Depends on utx_pkg, utx_front, utx_queue, utx_back.
//
// Usage: source bytes enter on in_item with push; an item is taken at an
// edge where push is high and full is low. Each source byte gives zero to
// six target bytes on out_item, read like a queue: data is valid while
// empty is low and is taken at an edge with pop high. The last byte caused
// by a source byte carries last_of_run.
// Configuration: valid/cfg_index/cfg_data, always ready; write only while
// the block is idle.
// Flow: with the back end idle, an accepted item goes into the request queue
// and its first byte then into the output register. The back end sends one
// byte per cycle while the output is popped or empty, at most six bytes per
// request, mark included; a queue of DEPTH requests lets the front keep
// accepting one byte per cycle while the back works, until the queue fills.
// Reset (synchronous, rst_n low) empties queue and output and restores
// register defaults. When pop stays low the output byte holds, the queue
// fills and full rises.
module unicode_text_transcoder_top #(
  parameter int unsigned DEPTH = utx_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  utx_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output utx_pkg::out_t out_item,
  input  logic          valid,
  output logic          ready,
  input  logic [1:0]    cfg_index,
  input  logic [1:0]    cfg_data
);

  utx_pkg::cfg_t    cfg_r, cfg_nxt;
  utx_pkg::entry_t  fe_entry, q_head;
  utx_pkg::q_stat_t q_stat;
  logic             accept, req_done;

  assign ready  = 1'b1;
  assign full   = q_stat.full;
  assign accept = push & ~q_stat.full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (valid) begin
      unique case (utx_pkg::reg_index_t'(cfg_index))
        utx_pkg::REG_SRC_ENC: cfg_nxt.src_enc = utx_pkg::src_enc_t'(cfg_data);
        utx_pkg::REG_SRC_ORD: cfg_nxt.src_ord = utx_pkg::order_t'(cfg_data);
        utx_pkg::REG_TGT_ENC: cfg_nxt.tgt_enc = utx_pkg::tgt_enc_t'(cfg_data);
        default:              cfg_nxt.tgt_ord = utx_pkg::order_t'(cfg_data);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_enc <= utx_pkg::SRC_UTF8;
      cfg_r.src_ord <= utx_pkg::ORD_AUTO;
      cfg_r.tgt_enc <= utx_pkg::TGT_UTF16;
      cfg_r.tgt_ord <= utx_pkg::ORD_LITTLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  utx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_item (in_item),
    .accept  (accept),
    .entry   (fe_entry)
  );

  utx_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .wr_data (fe_entry),
    .pop     (req_done),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  utx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req       (q_head),
    .req_valid (q_stat.valid),
    .req_done  (req_done),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("output or queue not cleared by reset");

  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_stat.valid)
    else $error("queue full without a head request");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> q_stat.valid)
    else $error("accepted item did not reach the request queue");

  a_no_phantom_out: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !q_stat.valid) |=> empty)
    else $error("output appeared with no queued request");

endmodule
